### sv/srt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types, codes and constants for the symbol rotation table.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int DEF_TABLE_ENTRIES = 64;
  localparam int SYM_W             = 21;
  localparam int ROT_W             = 3 * SYM_W;

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [1:0]       status_t;
  typedef logic [1:0]       kind_t;

  localparam kind_t KIND_LOOKUP = 2'd0;
  localparam kind_t KIND_DEFINE = 2'd1;
  localparam kind_t KIND_CLEAR  = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_BAD_SIZE  = 2'd1;
  localparam status_t ST_DUPLICATE = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  localparam logic [3:0] TUPLE_PAIR = 4'd2;
  localparam logic [3:0] TUPLE_QUAD = 4'd4;

  localparam logic [2:0] REG_STRICT_MODE = 3'd0;

  typedef struct packed {
    kind_t              kind;
    sym_t               symbol_a;
    sym_t               symbol_b;
    sym_t               symbol_c;
    sym_t               symbol_d;
    logic [3:0]         tuple_size;
    logic signed [31:0] turns;
  } in_item_t;

  typedef struct packed {
    sym_t    result_symbol;
    status_t status;
  } out_result_t;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_DEFINE,
    OP_CLEAR,
    OP_REPLY
  } op_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    op_t                   op;
    logic [3:0][SYM_W-1:0] sym;     // sym[0] is symbol_a
    logic                  quad;    // tuple of four, else two
    logic [1:0]            rot_n;   // |turns| mod 4
    status_t               status;  // reply status for OP_REPLY
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_ENC,
    S_ACT,
    S_READ,
    S_DONE
  } state_t;

endpackage

### sv/srt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_front
// Accepts input transfers, classifies them and queues commands (2 deep).
// ----------------------------------------------------------------------------
module srt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  srt_pkg::in_item_t in_item,
  output logic              cmd_valid,
  output srt_pkg::cmd_t     cmd,
  input  logic              cmd_pop
);

  srt_pkg::cmd_t cls;
  srt_pkg::cmd_t q_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push, do_pop;
  logic [1:0]    neg_low;

  // low bits of -turns depend only on the low bits of turns
  assign neg_low = 2'b00 - in_item.turns[1:0];

  always_comb begin
    cls        = '0;
    cls.sym[0] = in_item.symbol_a;
    cls.sym[1] = in_item.symbol_b;
    cls.sym[2] = in_item.symbol_c;
    cls.sym[3] = in_item.symbol_d;
    cls.quad   = (in_item.tuple_size == srt_pkg::TUPLE_QUAD);
    cls.rot_n  = in_item.turns[31] ? neg_low : in_item.turns[1:0];
    cls.status = srt_pkg::ST_OK;
    case (in_item.kind)
      srt_pkg::KIND_LOOKUP: cls.op = srt_pkg::OP_LOOKUP;
      srt_pkg::KIND_DEFINE: begin
        if (in_item.tuple_size inside {srt_pkg::TUPLE_PAIR, srt_pkg::TUPLE_QUAD}) begin
          cls.op = srt_pkg::OP_DEFINE;
        end else begin
          cls.op     = srt_pkg::OP_REPLY;
          cls.status = srt_pkg::ST_BAD_SIZE;
        end
      end
      srt_pkg::KIND_CLEAR: cls.op = srt_pkg::OP_CLEAR;
      default:             cls.op = srt_pkg::OP_REPLY;
    endcase
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

### sv/srt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_back
// Executes commands: parallel key match, rotation memory, result register.
// ----------------------------------------------------------------------------
module srt_back #(
  parameter int TABLE_ENTRIES = srt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 strict,
  input  logic                 cmd_valid,
  input  srt_pkg::cmd_t        cmd,
  output logic                 cmd_pop,
  output logic                 empty,
  input  logic                 pop,
  output srt_pkg::out_result_t out_result
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int SW = srt_pkg::SYM_W;

  srt_pkg::state_t state_r, state_nxt;
  srt_pkg::cmd_t   cmd_r;
  logic [1:0]      mi_r;
  logic [TABLE_ENTRIES-1:0] valid_r, match_r, cmp;
  logic [SW-1:0]   key_r [TABLE_ENTRIES];
  logic [srt_pkg::ROT_W-1:0] rot_mem [TABLE_ENTRIES];
  logic [srt_pkg::ROT_W-1:0] rd_data_r, rot_wr;
  logic            hit_r;
  logic [IW-1:0]   idx_r, idx_enc, slot;
  logic [CW-1:0]   count_r;
  srt_pkg::sym_t   cur_sym;
  srt_pkg::sym_t   res_sym_r, res_sym_nxt;
  srt_pkg::status_t res_status_r, res_status_nxt;
  logic            out_valid_r;
  srt_pkg::out_result_t out_data_r;

  logic dup, tbl_full, last, out_free;
  logic clear_en, match_en, enc_en, rd_en, wr_en, ins_en, mi_inc, res_load, out_load;

  assign cur_sym  = cmd_r.sym[mi_r];
  assign dup      = hit_r && strict;
  assign tbl_full = !hit_r && (count_r == CW'(TABLE_ENTRIES));
  assign last     = (mi_r == (cmd_r.quad ? 2'd3 : 2'd1));
  assign out_free = !out_valid_r || pop;
  assign slot     = hit_r ? idx_r : count_r[IW-1:0];

  // one comparator per entry
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      cmp[i] = valid_r[i] && (key_r[i] == cur_sym);
    end
  end

  // keys are unique among valid entries, so an OR encode is enough
  always_comb begin
    idx_enc = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (match_r[i]) begin
        idx_enc = idx_enc | IW'(i);
      end
    end
  end

  // next three tuple members, cyclic over the tuple size
  always_comb begin
    logic [1:0] k;
    rot_wr = '0;
    for (int j = 0; j < 3; j++) begin
      k = (mi_r + 2'(j + 1)) & (cmd_r.quad ? 2'd3 : 2'd1);
      rot_wr[SW*j +: SW] = cmd_r.sym[k];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srt_pkg::S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            srt_pkg::OP_LOOKUP:
              state_nxt = (cmd.rot_n == 2'd0) ? srt_pkg::S_DONE : srt_pkg::S_MATCH;
            srt_pkg::OP_DEFINE: state_nxt = srt_pkg::S_MATCH;
            default:            state_nxt = srt_pkg::S_DONE;
          endcase
        end
      end
      srt_pkg::S_MATCH: state_nxt = srt_pkg::S_ENC;
      srt_pkg::S_ENC:   state_nxt = srt_pkg::S_ACT;
      srt_pkg::S_ACT: begin
        if (cmd_r.op == srt_pkg::OP_LOOKUP) begin
          state_nxt = hit_r ? srt_pkg::S_READ : srt_pkg::S_DONE;
        end else if (dup || tbl_full || last) begin
          state_nxt = srt_pkg::S_DONE;
        end else begin
          state_nxt = srt_pkg::S_MATCH;
        end
      end
      srt_pkg::S_READ: state_nxt = srt_pkg::S_DONE;
      srt_pkg::S_DONE: state_nxt = out_free ? srt_pkg::S_IDLE : srt_pkg::S_DONE;
      default:         state_nxt = srt_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_pop        = 1'b0;
    clear_en       = 1'b0;
    match_en       = 1'b0;
    enc_en         = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    ins_en         = 1'b0;
    mi_inc         = 1'b0;
    res_load       = 1'b0;
    out_load       = 1'b0;
    res_sym_nxt    = '0;
    res_status_nxt = srt_pkg::ST_OK;
    case (state_r)
      srt_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          res_load = 1'b1;
          case (cmd.op)
            srt_pkg::OP_LOOKUP: res_sym_nxt    = cmd.sym[0];
            srt_pkg::OP_CLEAR:  clear_en       = 1'b1;
            srt_pkg::OP_REPLY:  res_status_nxt = cmd.status;
            default:            res_sym_nxt    = '0;
          endcase
        end
      end
      srt_pkg::S_MATCH: match_en = 1'b1;
      srt_pkg::S_ENC:   enc_en   = 1'b1;
      srt_pkg::S_ACT: begin
        if (cmd_r.op == srt_pkg::OP_LOOKUP) begin
          rd_en = hit_r;
        end else begin
          res_load = 1'b1;
          if (dup) begin
            res_status_nxt = srt_pkg::ST_DUPLICATE;
          end else if (tbl_full) begin
            res_status_nxt = srt_pkg::ST_FULL;
          end else begin
            wr_en  = 1'b1;
            ins_en = !hit_r;
            mi_inc = !last;
          end
        end
      end
      srt_pkg::S_READ: begin
        res_load = 1'b1;
        case (cmd_r.rot_n)
          2'd1:    res_sym_nxt = rd_data_r[0 +: SW];
          2'd2:    res_sym_nxt = rd_data_r[SW +: SW];
          2'd3:    res_sym_nxt = rd_data_r[2*SW +: SW];
          default: res_sym_nxt = cmd_r.sym[0];
        endcase
      end
      srt_pkg::S_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srt_pkg::S_IDLE;
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clear_en) begin
        valid_r <= '0;
        count_r <= '0;
      end else if (ins_en) begin
        valid_r[count_r[IW-1:0]] <= 1'b1;
        count_r                  <= count_r + CW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd;
      mi_r  <= 2'd0;
    end else if (mi_inc) begin
      mi_r <= mi_r + 2'd1;
    end
    if (match_en) begin
      match_r <= cmp;
    end
    if (enc_en) begin
      hit_r <= |match_r;
      idx_r <= idx_enc;
    end
    if (ins_en) begin
      key_r[count_r[IW-1:0]] <= cur_sym;
    end
    if (res_load) begin
      res_sym_r    <= res_sym_nxt;
      res_status_r <= res_status_nxt;
    end
    if (out_load) begin
      out_data_r.result_symbol <= res_sym_r;
      out_data_r.status        <= res_status_r;
    end
  end

  // rotation memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rot_mem[slot] <= rot_wr;
    end
    if (rd_en) begin
      rd_data_r <= rot_mem[idx_r];
    end
  end

  assign empty      = !out_valid_r;
  assign out_result = out_data_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("valid bits disagree with entry count");

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == srt_pkg::S_ENC |-> $onehot0(match_r))
    else $error("key present in more than one entry");

  a_dup_strict: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && res_status_r == srt_pkg::ST_DUPLICATE |-> strict)
    else $error("duplicate status outside strict mode");

endmodule

### sv/symbol_rotation_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_rotation_table
// Keyed table of code points and their three quarter-turn rotations.
// ----------------------------------------------------------------------------
// Usage:
//  - Input queue: drive in_item and raise push; a transfer happens when push
//    is high and full is low. A two-deep command queue sits behind it.
//  - Result queue: one result per item, in order. While empty is low the
//    oldest result is on out_result; pop takes it.
//  - Config: APB-style write of strict_mode at byte address 0, pready tied
//    high, reads return the register.
//  - Item handling, set by the back-end sequencer (take, then match, encode,
//    act per tuple member, a memory read on a lookup hit, then the result):
//      clear, bad size, unused kind, lookup with zero turns: take, result
//      lookup with non-zero turns: match, encode, act, then a read on a hit
//      define: match, encode and act per member, ending on duplicate or full
//    Items are handled one at a time: the back end takes the next command
//    only once the last result has moved to the output register.
//  - Reset (synchronous, rst_n low) empties the table and both queues and
//    clears strict_mode. No clearing pass is needed: entries fill in order from
//    slot 0 and only a clear or reset empties them, so valid bits track the fill count.
//  - When the receiver stalls, the finished result waits in the output
//    register, the back end holds its next result, and the command queue
//    keeps taking items until it is full.
// ----------------------------------------------------------------------------
module symbol_rotation_table #(
  parameter int TABLE_ENTRIES = srt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input queue
  input  logic                 push,
  output logic                 full,
  input  srt_pkg::in_item_t    in_item,
  // result queue
  output logic                 empty,
  input  logic                 pop,
  output srt_pkg::out_result_t out_result,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic          strict_r, strict_nxt;
  logic          cfg_wr;
  logic          cmd_valid, cmd_pop;
  srt_pkg::cmd_t cmd;

  // register file: a single bit
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    strict_nxt = strict_r;
    if (cfg_wr && paddr == srt_pkg::REG_STRICT_MODE) begin
      strict_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r <= 1'b0;
    end else begin
      strict_r <= strict_nxt;
    end
  end

  // reads of any other address return zero
  assign prdata = (paddr == srt_pkg::REG_STRICT_MODE) ? {31'd0, strict_r} : 32'd0;

  // front end: classify and queue
  srt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // back end: table, rotation memory and result register
  srt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .strict     (strict_r),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .empty      (empty),
    .pop        (pop),
    .out_result (out_result)
  );

endmodule
